### sv/vcd_pkg.sv
// Shared types, codes and constants of the vending change dispenser.
package vcd_pkg;

   // Field widths fixed by the interface.
   localparam int OP_W       = 2;
   localparam int CENTS_W    = 14;
   localparam int LOAD_W     = 8;
   localparam int COIN_OUT_W = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNTER_W  = 16;

   // Default width of each coin stock count.
   localparam int COIN_COUNT_BITS_DEF = 8;

   // Coin and bill values in cents.
   localparam int DOLLAR_CENTS  = 100;
   localparam int QUARTER_CENTS = 25;
   localparam int DIME_CENTS    = 10;
   localparam int NICKEL_CENTS  = 5;
   localparam int TOTAL_MAX     = 16383;

   // Reciprocal constants: floor(x / c) == (x * RECIP) >> SHIFT for all 14-bit x.
   localparam int QUARTER_RECIP = 5243;
   localparam int QUARTER_SHIFT = 17;
   localparam int DIME_RECIP    = 52429;
   localparam int DIME_SHIFT    = 19;
   localparam int NICKEL_RECIP  = 52429;
   localparam int NICKEL_SHIFT  = 18;
   localparam int DOLLAR_RECIP  = 5243;
   localparam int DOLLAR_SHIFT  = 19;

   // Widths of the quotients of a 14-bit amount.
   localparam int QDIV_W = 10;
   localparam int DDIV_W = 11;
   localparam int NDIV_W = 12;
   localparam int DOL_W  = 8;

   // Product widths for the reciprocal multiplications.
   localparam int QPROD_W = 27;
   localparam int DPROD_W = 30;
   localparam int NPROD_W = 30;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Operation codes on the input channel.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd2;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_SOLD         = 3'd0,
      ST_CANCEL       = 3'd1,
      ST_SHORT_MONEY  = 3'd2,
      ST_SHORT_CHANGE = 3'd3,
      ST_ACCEPTED     = 3'd4
   } status_type;

   // Classified command kinds.
   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_FINISH,
      CMD_LOAD,
      CMD_NOP
   } cmd_kind_type;

   // One classified item as it sits in the queue.
   typedef struct packed {
      cmd_kind_type        kind;
      logic                start_entry;
      logic                add_dollar;
      logic [CENTS_W-1:0]  price_cents;
      logic [LOAD_W-1:0]   load_quarters;
      logic [LOAD_W-1:0]   load_dimes;
      logic [LOAD_W-1:0]   load_nickels;
   } cmd_type;

   // Back-end sequencer states.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_QDIV,
      BK_QMIN,
      BK_DDIV,
      BK_DMIN,
      BK_NDIV,
      BK_NMIN
   } bk_state_type;

endpackage

### sv/vcd_front.sv
// Front end: accepts input items and classifies them into queue commands.
module vcd_front (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [vcd_pkg::OP_W-1:0]     req_op,
   input  logic [vcd_pkg::CENTS_W-1:0]  req_value_cents,
   input  logic [vcd_pkg::CENTS_W-1:0]  req_price_cents,
   input  logic [vcd_pkg::LOAD_W-1:0]   req_load_quarters,
   input  logic [vcd_pkg::LOAD_W-1:0]   req_load_dimes,
   input  logic [vcd_pkg::LOAD_W-1:0]   req_load_nickels,
   input  logic                         queue_full,
   output logic                         push,
   output vcd_pkg::cmd_type             cmd
);

   localparam int CW = vcd_pkg::CENTS_W;

   // The front holds off the sender only while the queue is full.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Decode the operation and reduce the inserted value to two flags.
   always_comb begin
      cmd.start_entry   = 1'b0;
      cmd.add_dollar    = 1'b0;
      cmd.price_cents   = req_price_cents;
      cmd.load_quarters = req_load_quarters;
      cmd.load_dimes    = req_load_dimes;
      cmd.load_nickels  = req_load_nickels;
      case (req_op)
         vcd_pkg::OP_INSERT: begin
            cmd.kind        = vcd_pkg::CMD_INSERT;
            cmd.start_entry = (req_value_cents != '0);
            cmd.add_dollar  = (req_value_cents == CW'(vcd_pkg::DOLLAR_CENTS));
         end
         vcd_pkg::OP_FINISH: cmd.kind = vcd_pkg::CMD_FINISH;
         vcd_pkg::OP_LOAD:   cmd.kind = vcd_pkg::CMD_LOAD;
         default:            cmd.kind = vcd_pkg::CMD_NOP;
      endcase
   end

endmodule

### sv/vcd_queue.sv
// Short command queue between the front end and the back end.
module vcd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vcd_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output vcd_pkg::cmd_type  head_cmd
);

   localparam int DEPTH = vcd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vcd_pkg::cmd_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and occupancy update with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### sv/vcd_back.sv
// Back end: keeps the machine state, makes change and holds the result register.
module vcd_back #(
   parameter int COIN_COUNT_BITS = vcd_pkg::COIN_COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  vcd_pkg::cmd_type                cmd,
   output logic                            cmd_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [vcd_pkg::STATUS_W-1:0]    rsp_status,
   output logic [vcd_pkg::CENTS_W-1:0]     rsp_change_cents,
   output logic [vcd_pkg::COIN_OUT_W-1:0]  rsp_quarters_out,
   output logic [vcd_pkg::COIN_OUT_W-1:0]  rsp_dimes_out,
   output logic [vcd_pkg::COIN_OUT_W-1:0]  rsp_nickels_out
);

   localparam int CCB    = COIN_COUNT_BITS;
   localparam int CW     = vcd_pkg::CENTS_W;
   localparam int OW     = vcd_pkg::COIN_OUT_W;
   localparam int KW     = vcd_pkg::COUNTER_W;
   localparam int QDW    = vcd_pkg::QDIV_W;
   localparam int DDW    = vcd_pkg::DDIV_W;
   localparam int NDW    = vcd_pkg::NDIV_W;
   localparam int DLW    = vcd_pkg::DOL_W;
   localparam int QPW    = vcd_pkg::QPROD_W;
   localparam int DPW    = vcd_pkg::DPROD_W;
   localparam int NPW    = vcd_pkg::NPROD_W;
   localparam int QCMP_W = (CCB > QDW) ? CCB : QDW;
   localparam int DCMP_W = (CCB > DDW) ? CCB : DDW;
   localparam int NCMP_W = (CCB > NDW) ? CCB : NDW;
   localparam int QC_W   = CCB + 5;
   localparam int DC_W   = CCB + 4;
   localparam int NC_W   = CCB + 3;

   // Sequencer state.
   vcd_pkg::bk_state_type state_ff, state_in;

   // Machine state.
   logic [CW-1:0]   total_ff;
   logic            started_ff;
   logic [CCB-1:0]  qstock_ff, dstock_ff, nstock_ff;
   logic [KW-1:0]   dollars_ff, sales_ff;

   // Change-making work registers.
   logic [CW-1:0]   amt_ff, rem_ff, rem2_ff;
   logic [QDW-1:0]  qdiv_ff;
   logic [DDW-1:0]  ddiv_ff;
   logic [NDW-1:0]  ndiv_ff;
   logic [DLW-1:0]  dol_add_ff;
   logic [CCB-1:0]  nq_ff, nd_ff;

   // Result register.
   logic                 rsp_valid_ff;
   vcd_pkg::status_type  rsp_status_ff;
   logic [CW-1:0]        rsp_change_ff;
   logic [OW-1:0]        rsp_q_ff, rsp_d_ff, rsp_n_ff;

   // Control decoded from the state.
   logic                 out_free, fin_go, res_load, res_sale;
   logic                 sale_commit, retry, entry_clear, success;
   vcd_pkg::status_type  res_status;

   // Datapath terms.
   logic [QPW-1:0]     qprod, dolprod;
   logic [DPW-1:0]     dprod;
   logic [NPW-1:0]     nprod;
   logic [CCB-1:0]     nq_sel, nd_sel, nn_sel;
   logic [QC_W-1:0]    nq_cents;
   logic [DC_W-1:0]    nd_cents;
   logic [NC_W-1:0]    nn_cents;
   logic [CW-1:0]      rem3;
   logic [KW:0]        sales_sum, dollars_sum;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Quotients by reciprocal multiplication, each registered before use.
   assign qprod   = QPW'(amt_ff) * QPW'(vcd_pkg::QUARTER_RECIP);
   assign dolprod = QPW'(total_ff) * QPW'(vcd_pkg::DOLLAR_RECIP);
   assign dprod   = DPW'(rem_ff) * DPW'(vcd_pkg::DIME_RECIP);
   assign nprod   = NPW'(rem2_ff) * NPW'(vcd_pkg::NICKEL_RECIP);

   // Each coin count is the quotient clipped to the stock.
   assign nq_sel = (QCMP_W'(qdiv_ff) < QCMP_W'(qstock_ff)) ? CCB'(qdiv_ff) : qstock_ff;
   assign nd_sel = (DCMP_W'(ddiv_ff) < DCMP_W'(dstock_ff)) ? CCB'(ddiv_ff) : dstock_ff;
   assign nn_sel = (NCMP_W'(ndiv_ff) < NCMP_W'(nstock_ff)) ? CCB'(ndiv_ff) : nstock_ff;

   assign nq_cents = QC_W'(nq_sel) * QC_W'(vcd_pkg::QUARTER_CENTS);
   assign nd_cents = DC_W'(nd_sel) * DC_W'(vcd_pkg::DIME_CENTS);
   assign nn_cents = NC_W'(nn_sel) * NC_W'(vcd_pkg::NICKEL_CENTS);

   // The split succeeds when the nickels leave nothing over.
   assign rem3    = rem2_ff - CW'(nn_cents);
   assign success = (rem3 == '0);

   // Saturating counters.
   assign sales_sum   = (KW+1)'(sales_ff) + (KW+1)'(1);
   assign dollars_sum = (KW+1)'(dollars_ff) + (KW+1)'(dol_add_ff);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vcd_pkg::BK_IDLE: if (fin_go) state_in = vcd_pkg::BK_QDIV;
         vcd_pkg::BK_QDIV: state_in = vcd_pkg::BK_QMIN;
         vcd_pkg::BK_QMIN: state_in = vcd_pkg::BK_DDIV;
         vcd_pkg::BK_DDIV: state_in = vcd_pkg::BK_DMIN;
         vcd_pkg::BK_DMIN: state_in = vcd_pkg::BK_NDIV;
         vcd_pkg::BK_NDIV: state_in = vcd_pkg::BK_NMIN;
         vcd_pkg::BK_NMIN: begin
            if (retry) begin
               state_in = vcd_pkg::BK_DDIV;
            end else if (out_free) begin
               state_in = vcd_pkg::BK_IDLE;
            end
         end
         default: state_in = vcd_pkg::BK_IDLE;
      endcase
   end

   // Output and control decoding.
   always_comb begin
      cmd_pop     = 1'b0;
      fin_go      = 1'b0;
      res_load    = 1'b0;
      res_sale    = 1'b0;
      res_status  = vcd_pkg::ST_ACCEPTED;
      sale_commit = 1'b0;
      retry       = 1'b0;
      entry_clear = 1'b0;
      case (state_ff)
         vcd_pkg::BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  vcd_pkg::CMD_FINISH: begin
                     if (!started_ff) begin
                        res_load    = 1'b1;
                        res_status  = vcd_pkg::ST_CANCEL;
                        entry_clear = 1'b1;
                     end else if (total_ff < cmd.price_cents) begin
                        res_load    = 1'b1;
                        res_status  = vcd_pkg::ST_SHORT_MONEY;
                        entry_clear = 1'b1;
                     end else begin
                        fin_go = 1'b1;
                     end
                  end
                  default: res_load = 1'b1;
               endcase
            end
         end
         vcd_pkg::BK_NMIN: begin
            if (success) begin
               if (out_free) begin
                  res_load    = 1'b1;
                  res_sale    = 1'b1;
                  res_status  = vcd_pkg::ST_SOLD;
                  sale_commit = 1'b1;
                  entry_clear = 1'b1;
               end
            end else if (nq_ff == '0) begin
               if (out_free) begin
                  res_load    = 1'b1;
                  res_status  = vcd_pkg::ST_SHORT_CHANGE;
                  entry_clear = 1'b1;
               end
            end else begin
               retry = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Sequencer, machine state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vcd_pkg::BK_IDLE;
         total_ff     <= '0;
         started_ff   <= 1'b0;
         qstock_ff    <= '0;
         dstock_ff    <= '0;
         nstock_ff    <= '0;
         dollars_ff   <= '0;
         sales_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd_pop && cmd.kind == vcd_pkg::CMD_INSERT) begin
            if (cmd.start_entry) begin
               started_ff <= 1'b1;
            end
            if (cmd.add_dollar &&
                total_ff <= CW'(vcd_pkg::TOTAL_MAX - vcd_pkg::DOLLAR_CENTS)) begin
               total_ff <= total_ff + CW'(vcd_pkg::DOLLAR_CENTS);
            end
         end
         if (cmd_pop && cmd.kind == vcd_pkg::CMD_LOAD) begin
            qstock_ff <= CCB'(cmd.load_quarters);
            dstock_ff <= CCB'(cmd.load_dimes);
            nstock_ff <= CCB'(cmd.load_nickels);
         end
         if (entry_clear) begin
            total_ff   <= '0;
            started_ff <= 1'b0;
         end
         if (sale_commit) begin
            qstock_ff  <= qstock_ff - nq_ff;
            dstock_ff  <= dstock_ff - nd_ff;
            nstock_ff  <= nstock_ff - nn_sel;
            sales_ff   <= sales_sum[KW] ? '1 : sales_sum[KW-1:0];
            dollars_ff <= dollars_sum[KW] ? '1 : dollars_sum[KW-1:0];
         end
      end
   end

   // Change-making work registers, one step per state.
   always_ff @(posedge clock) begin
      case (state_ff)
         vcd_pkg::BK_IDLE: begin
            if (fin_go) begin
               amt_ff <= total_ff - cmd.price_cents;
            end
         end
         vcd_pkg::BK_QDIV: begin
            qdiv_ff    <= qprod[vcd_pkg::QUARTER_SHIFT +: QDW];
            dol_add_ff <= dolprod[vcd_pkg::DOLLAR_SHIFT +: DLW];
         end
         vcd_pkg::BK_QMIN: begin
            nq_ff  <= nq_sel;
            rem_ff <= amt_ff - CW'(nq_cents);
         end
         vcd_pkg::BK_DDIV: ddiv_ff <= dprod[vcd_pkg::DIME_SHIFT +: DDW];
         vcd_pkg::BK_DMIN: begin
            nd_ff   <= nd_sel;
            rem2_ff <= rem_ff - CW'(nd_cents);
         end
         vcd_pkg::BK_NDIV: ndiv_ff <= nprod[vcd_pkg::NICKEL_SHIFT +: NDW];
         vcd_pkg::BK_NMIN: begin
            if (retry) begin
               nq_ff  <= nq_ff - 1'b1;
               rem_ff <= rem_ff + CW'(vcd_pkg::QUARTER_CENTS);
            end
         end
         default: ;
      endcase
   end

   // Result payload; non-sale results carry no change.
   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_status_ff <= res_status;
         if (res_sale) begin
            rsp_change_ff <= amt_ff;
            rsp_q_ff      <= OW'(nq_ff);
            rsp_d_ff      <= OW'(nd_ff);
            rsp_n_ff      <= OW'(nn_sel);
         end else begin
            rsp_change_ff <= '0;
            rsp_q_ff      <= '0;
            rsp_d_ff      <= '0;
            rsp_n_ff      <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_change_cents = rsp_change_ff;
   assign rsp_quarters_out = rsp_q_ff;
   assign rsp_dimes_out    = rsp_d_ff;
   assign rsp_nickels_out  = rsp_n_ff;

endmodule

### sv/vending_change_dispenser.sv
// Top level of the vending change dispenser: front end, command queue and back end.
//
//  Channel | Direction | Handshake          | Fields
//  req     | in        | req_valid/req_stall | op, value_cents, price_cents, load_*
//  rsp     | out       | rsp_valid/rsp_stall | status, change_cents, *_out
//
// Insert, load and unused items stay in the idle state; each gives one result.
// A finish item that reaches change making runs the quarter, dime and nickel
// division and clipping states; while the split fails and a quarter can be given
// up, it drops one quarter and reruns the dime and nickel states.
// Reset is synchronous and active high and clears all stock, totals and counters.
// A two-entry queue lets the front keep accepting while the back works or the
// result register waits on rsp_stall.
module vending_change_dispenser #(
   parameter int COIN_COUNT_BITS = vcd_pkg::COIN_COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [vcd_pkg::OP_W-1:0]        req_op,
   input  logic [vcd_pkg::CENTS_W-1:0]     req_value_cents,
   input  logic [vcd_pkg::CENTS_W-1:0]     req_price_cents,
   input  logic [vcd_pkg::LOAD_W-1:0]      req_load_quarters,
   input  logic [vcd_pkg::LOAD_W-1:0]      req_load_dimes,
   input  logic [vcd_pkg::LOAD_W-1:0]      req_load_nickels,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [vcd_pkg::STATUS_W-1:0]    rsp_status,
   output logic [vcd_pkg::CENTS_W-1:0]     rsp_change_cents,
   output logic [vcd_pkg::COIN_OUT_W-1:0]  rsp_quarters_out,
   output logic [vcd_pkg::COIN_OUT_W-1:0]  rsp_dimes_out,
   output logic [vcd_pkg::COIN_OUT_W-1:0]  rsp_nickels_out
);

   logic              push, queue_full, head_valid, pop;
   vcd_pkg::cmd_type  front_cmd, head_cmd;

   // Classify items as they arrive.
   vcd_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_value_cents   (req_value_cents),
      .req_price_cents   (req_price_cents),
      .req_load_quarters (req_load_quarters),
      .req_load_dimes    (req_load_dimes),
      .req_load_nickels  (req_load_nickels),
      .queue_full        (queue_full),
      .push              (push),
      .cmd               (front_cmd)
   );

   // Decouple the front from the back.
   vcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Carry out commands and make change.
   vcd_back #(
      .COIN_COUNT_BITS (COIN_COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (head_valid),
      .cmd              (head_cmd),
      .cmd_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_change_cents (rsp_change_cents),
      .rsp_quarters_out (rsp_quarters_out),
      .rsp_dimes_out    (rsp_dimes_out),
      .rsp_nickels_out  (rsp_nickels_out)
   );

   // A sale pays out exactly the change owed.
   a_sale_sum : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == vcd_pkg::ST_SOLD |->
         (16'(rsp_quarters_out) * 16'(vcd_pkg::QUARTER_CENTS)
          + 16'(rsp_dimes_out) * 16'(vcd_pkg::DIME_CENTS)
          + 16'(rsp_nickels_out) * 16'(vcd_pkg::NICKEL_CENTS))
         == 16'(rsp_change_cents))
      else $error("sale coins do not add up to the change");

   // Anything but a sale carries no change and no coins.
   a_no_sale_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != vcd_pkg::ST_SOLD |->
         rsp_change_cents == '0 && rsp_quarters_out == '0
         && rsp_dimes_out == '0 && rsp_nickels_out == '0)
      else $error("non-sale result carries change");

   // No item is popped from the queue while the result register is stuck.
   a_pop_free : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && (!rsp_valid || !rsp_stall))
      else $error("queue popped with no room for the result");

endmodule
